### sv/mec_pkg.sv
// ----------------------------------------------------------------------------
// mec_pkg
// Shared types and constants for the Mandelbrot escape count block.
// ----------------------------------------------------------------------------
package mec_pkg;

  localparam int COORD_W     = 64;
  localparam int WIDE_W      = 128;
  localparam int HALF_W      = 32;
  localparam int COUNT_W     = 17;
  localparam int LIMIT_W     = 16;
  localparam int ESCAPE_LOG2 = 4;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd1000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL,
    ST_ACC,
    ST_EVAL,
    ST_UPDATE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic       load;
    logic       prep;
    logic       mul_en;
    logic [1:0] phase;
    logic       eval_en;
    logic       inc_iter;
    logic       finish;
    logic       update;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic limit_hit;
    logic escape;
    logic out_free;
  } status_t;

endpackage

### sv/mec_datapath.sv
// ----------------------------------------------------------------------------
// mec_datapath
// Fixed point z = z^2 + c datapath: shared partial product multipliers,
// accumulators, escape compare, saturating update and result register.
// ----------------------------------------------------------------------------
module mec_datapath #(
  parameter int FRACTION_BITS = 60
) (
  input  logic                              clk,
  input  logic                              rst,
  input  mec_pkg::cmd_t                     cmd,
  output mec_pkg::status_t                  status,
  input  logic                              cfg_valid,
  input  logic [mec_pkg::LIMIT_W-1:0]       cfg_data,
  input  logic signed [mec_pkg::COORD_W-1:0] c_real,
  input  logic signed [mec_pkg::COORD_W-1:0] c_imag,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [mec_pkg::COUNT_W-1:0]       count,
  output logic                              escaped
);
  import mec_pkg::*;

  localparam logic [WIDE_W-1:0] ESC_THRESHOLD =
    WIDE_W'(1) << (2 * FRACTION_BITS + ESCAPE_LOG2);

  function automatic logic signed [COORD_W-1:0] sat64(input logic signed [WIDE_W-1:0] v);
    logic fits;
    fits = (v[WIDE_W-1:COORD_W-1] == {(WIDE_W-COORD_W+1){v[COORD_W-1]}});
    if (fits)
      sat64 = v[COORD_W-1:0];
    else if (v[WIDE_W-1])
      sat64 = {1'b1, {(COORD_W-1){1'b0}}};
    else
      sat64 = {1'b0, {(COORD_W-1){1'b1}}};
  endfunction

  logic [LIMIT_W-1:0]        limit;
  logic signed [COORD_W-1:0] cr, ci, x, y;
  logic [COORD_W-1:0]        mag_x, mag_y;
  logic                      neg_xy;
  logic [2*HALF_W-1:0]       prod_xx, prod_yy, prod_xy;
  logic [1:0]                prod_sh;
  logic                      prod_vld;
  logic [WIDE_W-1:0]         acc_xx, acc_yy, acc_xy;
  logic signed [WIDE_W-1:0]  diff, xy_s;
  logic [COUNT_W-1:0]        iter;

  logic [HALF_W-1:0]         a_x, b_x, a_y, b_y;
  logic [6:0]                shamt;
  logic [WIDE_W-1:0]         sum_sq;
  logic signed [WIDE_W-1:0]  nx_full, ny_full;

  // config register, always ready
  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RESET;
    end else if (cfg_valid) begin
      limit <= cfg_data;
    end
  end

  // partial product operand select
  always_comb begin
    a_x   = cmd.phase[1] ? mag_x[2*HALF_W-1:HALF_W] : mag_x[HALF_W-1:0];
    b_x   = cmd.phase[0] ? mag_x[2*HALF_W-1:HALF_W] : mag_x[HALF_W-1:0];
    a_y   = cmd.phase[1] ? mag_y[2*HALF_W-1:HALF_W] : mag_y[HALF_W-1:0];
    b_y   = cmd.phase[0] ? mag_y[2*HALF_W-1:HALF_W] : mag_y[HALF_W-1:0];
    shamt = {prod_sh, 5'b00000};
  end

  always_comb begin
    sum_sq  = acc_xx + acc_yy;
    nx_full = (diff >>> FRACTION_BITS) +
              $signed({{(WIDE_W-COORD_W){cr[COORD_W-1]}}, cr});
    ny_full = (xy_s >>> (FRACTION_BITS - 1)) +
              $signed({{(WIDE_W-COORD_W){ci[COORD_W-1]}}, ci});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= cmd.mul_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cr   <= c_real;
      ci   <= c_imag;
      x    <= c_real;
      y    <= c_imag;
      iter <= '0;
    end
    if (cmd.prep) begin
      mag_x  <= x[COORD_W-1] ? COORD_W'(-x) : COORD_W'(x);
      mag_y  <= y[COORD_W-1] ? COORD_W'(-y) : COORD_W'(y);
      neg_xy <= x[COORD_W-1] ^ y[COORD_W-1];
      acc_xx <= '0;
      acc_yy <= '0;
      acc_xy <= '0;
    end
    if (cmd.mul_en) begin
      prod_xx <= a_x * b_x;
      prod_yy <= a_y * b_y;
      prod_xy <= a_x * b_y;
      prod_sh <= {1'b0, cmd.phase[1]} + {1'b0, cmd.phase[0]};
    end
    if (prod_vld) begin
      acc_xx <= acc_xx + ({{(WIDE_W-2*HALF_W){1'b0}}, prod_xx} << shamt);
      acc_yy <= acc_yy + ({{(WIDE_W-2*HALF_W){1'b0}}, prod_yy} << shamt);
      acc_xy <= acc_xy + ({{(WIDE_W-2*HALF_W){1'b0}}, prod_xy} << shamt);
    end
    if (cmd.eval_en) begin
      diff <= $signed(acc_xx - acc_yy);
      xy_s <= neg_xy ? $signed(-acc_xy) : $signed(acc_xy);
    end
    if (cmd.inc_iter) begin
      iter <= iter + 1'b1;
    end
    if (cmd.update) begin
      x <= sat64(nx_full);
      y <= sat64(ny_full);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      count   <= iter;
      escaped <= !status.limit_hit;
    end
  end

  always_comb begin
    status.limit_hit = iter > {1'b0, limit};
    status.escape    = sum_sq > ESC_THRESHOLD;
    status.out_free  = !out_valid || !out_stall;
  end

endmodule

### sv/mec_controller.sv
// ----------------------------------------------------------------------------
// mec_controller
// Sequencer for one point: prep, four multiply phases, accumulate,
// evaluate, update.
// ----------------------------------------------------------------------------
module mec_controller (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  mec_pkg::status_t status,
  output mec_pkg::cmd_t    cmd
);
  import mec_pkg::*;

  state_t     state, state_next;
  logic [1:0] phase, phase_next;
  logic       first, first_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      phase <= '0;
      first <= 1'b0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      first <= first_next;
    end
  end

  always_comb begin
    state_next = state;
    phase_next = phase;
    first_next = first;
    cmd        = '0;
    in_stall   = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          first_next = 1'b1;
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep   = 1'b1;
        phase_next = '0;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        cmd.phase  = phase;
        phase_next = phase + 1'b1;
        if (phase == 2'd3) begin
          state_next = ST_ACC;
        end
      end
      ST_ACC: begin
        state_next = ST_EVAL;
      end
      ST_EVAL: begin
        cmd.eval_en = 1'b1;
        priority if (first) begin
          state_next = ST_UPDATE;
        end else if (status.limit_hit || status.escape) begin
          if (status.out_free) begin
            cmd.finish = 1'b1;
            state_next = ST_IDLE;
          end
        end else begin
          cmd.inc_iter = 1'b1;
          state_next   = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        first_next = 1'b0;
        state_next = ST_PREP;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### sv/mandelbrot_escape_count.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_count
// Escape count of one complex point c in signed fixed point: z starts at
// c^2 + c and iterates z = z^2 + c until |z|^2 > 16 or the count passes
// the iteration limit.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake            payload
//   in       sink       in_valid / in_stall  c_real, c_imag
//   out      source     out_valid / out_stall count, escaped
//   cfg      sink       cfg_valid / cfg_ready cfg_data (iteration_limit)
//
// one pass over z runs magnitude prep, four partial product
// phases on three 32x32 multipliers (x*x, y*y, x*y), accumulate, evaluate
// and update; the final pass skips update.
// reset is synchronous; it clears the sequencer and output valid and puts the
// iteration limit back to 1000
// one point is in work at a time; a finished result waits in the output
// register and the next point is taken as soon as it is loaded there
// cfg_ready is always high; write the limit only while the block is idle
module mandelbrot_escape_count #(
  parameter int FRACTION_BITS = 60
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [mec_pkg::COORD_W-1:0] c_real,
  input  logic signed [mec_pkg::COORD_W-1:0] c_imag,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [mec_pkg::COUNT_W-1:0]        count,
  output logic                               escaped,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mec_pkg::LIMIT_W-1:0]        cfg_data
);
  import mec_pkg::*;

  cmd_t    cmd;
  status_t status;

  // the limit register takes a write transaction in any cycle
  assign cfg_ready = 1'b1;

  // sequencer: owns the input handshake and the pass loop
  mec_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // arithmetic, iteration count, limit register and result register
  mec_datapath #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .c_real    (c_real),
    .c_imag    (c_imag),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .count     (count),
    .escaped   (escaped)
  );

endmodule

### sv/mec_checker.sv
// ----------------------------------------------------------------------------
// mec_checker
// Port level checks for the escape count block, bound to the top level.
// ----------------------------------------------------------------------------
module mec_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic [mec_pkg::COUNT_W-1:0]        count,
  input logic                               escaped
);

  // stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(count) && $stable(escaped))
    else $error("result changed while stalled");

  // a point stopped by the limit has run at least one iteration
  a_limit_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && !escaped |-> count != '0)
    else $error("limit stop with zero count");

  // block is busy right after taking a point
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after accept");

  // a new result only comes out of a busy block
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without work in progress");

endmodule

bind mandelbrot_escape_count mec_checker u_mec_checker (.*);

### tb/mandelbrot_escape_count_tb.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_count_tb
// Self-checking bench for the escape count block: a directed table of points,
// then random sweeps across several iteration limits. Every result is checked
// against a typed answer or an in-bench fixed point model of the z = z^2 + c loop.
// ----------------------------------------------------------------------------
module mandelbrot_escape_count_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mec_pkg::*;

  localparam int FRAC           = 60;
  localparam int HALF_PERIOD    = 4;
  localparam int RESET_CYCLES   = 8;
  // sized for every point below the top limit running to its limit
  localparam int CYCLE_LIMIT    = 4_000_000;
  // a stray result would show up well within this window after the drain
  localparam int SETTLE_CYCLES  = 64;
  localparam int REPORT_MAX     = 10;
  localparam int PROBE_ROWS     = 25;
  localparam int PHASE_COUNT    = 8;
  localparam int POINTS_PLANNED = 585;

  localparam logic signed [COORD_W-1:0] ONE       = 64'sh1000_0000_0000_0000;
  localparam logic signed [COORD_W-1:0] TWO       = 64'sh2000_0000_0000_0000;
  localparam logic signed [COORD_W-1:0] HALF      = ONE >>> 1;
  localparam logic signed [COORD_W-1:0] QUARTER   = ONE >>> 2;
  localparam logic signed [COORD_W-1:0] MAX_COORD = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [COORD_W-1:0] MIN_COORD = 64'sh8000_0000_0000_0000;
  localparam logic [LIMIT_W-1:0]        MAX_LIMIT = {LIMIT_W{1'b1}};

  // |z|^2 compared at 2*FRAC fraction bits
  localparam logic [WIDE_W-1:0] ESCAPE_MAG = 128'd16 << (2 * FRAC);
  // |c| > 3 guarantees escape on the first test
  localparam logic [WIDE_W-1:0] FAR_MAG    = 128'd9 << (2 * FRAC);

  typedef struct packed {
    logic signed [COORD_W-1:0] re;
    logic signed [COORD_W-1:0] im;
  } coord_pair_t;

  typedef struct packed {
    logic [COUNT_W-1:0] cnt;
    logic               esc;
  } escape_result_t;

  // directed row: limit in force, point, and a typed answer where it is obvious
  typedef struct packed {
    logic [LIMIT_W-1:0]        limit;
    logic signed [COORD_W-1:0] re;
    logic signed [COORD_W-1:0] im;
    logic                      known;
    logic [COUNT_W-1:0]        cnt;
    logic                      esc;
  } probe_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] limit;
    logic               rand_limit;
    logic [9:0]         points;
  } sweep_phase_t;

  localparam probe_t PROBES [PROBE_ROWS] = '{
    // reset limit of 1000, never written
    '{16'd1000, 64'sd0,    64'sd0,    1'b1, 17'd1001, 1'b0},  // origin stays put
    '{16'd1000, MAX_COORD, MAX_COORD, 1'b1, 17'd0,    1'b1},  // saturates at once
    '{16'd1000, MIN_COORD, MIN_COORD, 1'b1, 17'd0,    1'b1},
    '{16'd1000, MAX_COORD, MIN_COORD, 1'b1, 17'd0,    1'b1},
    '{16'd1000, MIN_COORD, MAX_COORD, 1'b1, 17'd0,    1'b1},
    '{16'd1000, MIN_COORD, 64'sd0,    1'b1, 17'd0,    1'b1},
    '{16'd1000, 64'sd0,    MAX_COORD, 1'b1, 17'd0,    1'b1},
    '{16'd1000, -TWO,      64'sd0,    1'b1, 17'd1001, 1'b0},  // fixed point at z = 2
    '{16'd1000, -ONE,      64'sd0,    1'b1, 17'd1001, 1'b0},  // 0 / -1 orbit of period two
    '{16'd1000, TWO,       64'sd0,    1'b1, 17'd0,    1'b1},  // z = 6 right away
    '{16'd1000, 64'sd0,    ONE,       1'b0, 17'd0,    1'b0},
    '{16'd1000, QUARTER + (ONE >>> 10), 64'sd0, 1'b0, 17'd0, 1'b0},  // slow leak
    '{16'd1000, -(ONE / 4 * 3), ONE / 10, 1'b0, 17'd0, 1'b0},
    '{16'd1000, 64'sd1,    64'sd1,    1'b0, 17'd0,    1'b0},  // one lsb
    '{16'd1000, -64'sd1,   -64'sd1,   1'b0, 17'd0,    1'b0},  // floor rounding
    '{16'd1000, -TWO - 64'sd1, 64'sd0, 1'b0, 17'd0,   1'b0},
    '{16'd1000, -(ONE / 8), ONE / 20 * 13, 1'b0, 17'd0, 1'b0},
    // limits 0 and 1: once past the limit, the limit test wins even when |z| is already large
    '{16'd0,    64'sd0,    64'sd0,    1'b1, 17'd1,    1'b0},
    '{16'd0,    ONE,       64'sd0,    1'b1, 17'd1,    1'b0},
    '{16'd0,    TWO,       64'sd0,    1'b1, 17'd0,    1'b1},
    '{16'd1,    ONE,       64'sd0,    1'b1, 17'd1,    1'b1},
    // top limit, points that still escape in reasonable time
    '{16'hFFFF, QUARTER + (ONE >>> 12), 64'sd0, 1'b0, 17'd0, 1'b0},
    '{16'hFFFF, MAX_COORD, 64'sd0,    1'b1, 17'd0,    1'b1},
    '{16'hFFFF, -TWO - (ONE >>> 40), 64'sd0, 1'b0, 17'd0, 1'b0},
    '{16'hFFFF, 64'sd0,    TWO + 64'sd1, 1'b0, 17'd0, 1'b0}
  };

  // random sweeps; the top limit only gets points known to escape quickly
  localparam sweep_phase_t PHASES [PHASE_COUNT] = '{
    '{16'd0,     1'b0, 10'd50},
    '{16'd1,     1'b0, 10'd50},
    '{16'd3,     1'b0, 10'd60},
    '{16'hFFFF,  1'b0, 10'd40},
    '{16'd20,    1'b0, 10'd200},
    '{16'd255,   1'b0, 10'd40},
    '{16'd0,     1'b1, 10'd100},
    '{16'd1000,  1'b0, 10'd20}
  };

  logic                      clk       = 1'b0;
  logic                      rst       = 1'b1;
  logic                      in_valid  = 1'b0;
  logic                      in_stall;
  logic signed [COORD_W-1:0] c_real    = '0;
  logic signed [COORD_W-1:0] c_imag    = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [COUNT_W-1:0]        count;
  logic                      escaped;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [LIMIT_W-1:0]        cfg_data  = '0;

  // bench copy of the iteration limit register
  logic [LIMIT_W-1:0] limit_now = LIMIT_RESET;
  escape_result_t     pending_escapes [$];
  int unsigned        mismatches    = 0;
  int unsigned        results_seen  = 0;
  int unsigned        points_sent   = 0;
  int unsigned        cycles_run    = 0;
  int unsigned        send_idle_pct = 34;
  int unsigned        recv_idle_pct = 69;

  mandelbrot_escape_count #(
    .FRACTION_BITS(FRAC)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .c_real   (c_real),
    .c_imag   (c_imag),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .count    (count),
    .escaped  (escaped),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // ---------------------------------------------------------------------------
  // fixed point model
  // ---------------------------------------------------------------------------

  // wide value back into the coordinate range, clamping on overflow
  function automatic logic signed [COORD_W-1:0] clamp_coord(
      input logic signed [WIDE_W-1:0] v);
    if (v[WIDE_W-1:COORD_W-1] == {(WIDE_W-COORD_W+1){v[WIDE_W-1]}}) begin
      return v[COORD_W-1:0];
    end
    return v[WIDE_W-1] ? MIN_COORD : MAX_COORD;
  endfunction

  // exact x^2 + y^2, unsigned since it can reach 2^127
  function automatic logic [WIDE_W-1:0] magnitude_sq(input coord_pair_t z);
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [WIDE_W-1:0]  xx;
    logic signed [WIDE_W-1:0]  yy;
    x  = z.re;
    y  = z.im;
    xx = x * x;
    yy = y * y;
    return xx + yy;
  endfunction

  // one step of z <- z^2 + c; arithmetic shifts give floor rounding
  function automatic coord_pair_t square_add(input coord_pair_t z, input coord_pair_t c);
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] cr;
    logic signed [COORD_W-1:0] ci;
    logic signed [WIDE_W-1:0]  xx;
    logic signed [WIDE_W-1:0]  yy;
    logic signed [WIDE_W-1:0]  xy;
    logic signed [WIDE_W-1:0]  re_w;
    logic signed [WIDE_W-1:0]  im_w;
    coord_pair_t               n;
    x    = z.re;
    y    = z.im;
    cr   = c.re;
    ci   = c.im;
    xx   = x * x;
    yy   = y * y;
    xy   = x * y;
    re_w = ((xx - yy) >>> FRAC) + cr;
    im_w = (xy >>> (FRAC - 1)) + ci;   // 2xy folded into the shift
    n.re = clamp_coord(re_w);
    n.im = clamp_coord(im_w);
    return n;
  endfunction

  // escape count of c under a given limit; the limit test comes first
  function automatic escape_result_t predict_escape(input coord_pair_t c,
                                                    input logic [LIMIT_W-1:0] lim);
    coord_pair_t    z;
    int unsigned    iter;
    escape_result_t r;
    z     = square_add(c, c);
    r.esc = 1'b0;
    for (iter = 0; iter <= lim; iter++) begin
      if (magnitude_sq(z) > ESCAPE_MAG) begin
        r.esc = 1'b1;
        break;
      end
      z = square_add(z, c);
    end
    // falling out of the loop leaves iter at limit + 1
    r.cnt = iter[COUNT_W-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic signed [COORD_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // random point; slow_safe keeps to points that escape within a few hundred
  // passes so the top limit does not blow up the run time
  function automatic coord_pair_t pick_point(input logic slow_safe);
    coord_pair_t  c;
    logic [63:0]  u;
    int unsigned  kind;
    int unsigned  s;
    kind = $urandom_range(99);
    u    = {$urandom, $urandom};
    if (slow_safe) begin
      if (kind < 50) begin
        // anything with |c| > 3
        do begin
          c.re = rand64();
          c.im = rand64();
        end while (magnitude_sq(c) <= FAR_MAG);
      end else if (kind < 80) begin
        // just right of the cusp: count grows like pi / sqrt(eps)
        s    = $urandom_range(6, 14);
        c.re = QUARTER + (ONE >>> s) + (u >> (s + 5));
        c.im = '0;
      end else begin
        // just left of the tip: tiny offsets grow fourfold per pass
        s    = $urandom_range(6, 58);
        c.re = -TWO - (ONE >>> s) - (u >> (s + 5));
        c.im = '0;
      end
    end else if (kind < 50) begin
      // box around the set, most points escape after a few passes
      c.re = (rand64() >>> 2) - HALF;
      c.im = rand64() >>> 2;
    end else if (kind < 70) begin
      // raw bit patterns, mostly saturating
      c.re = rand64();
      c.im = rand64();
    end else if (kind < 80) begin
      s    = $urandom_range(4, 58);
      c.re = QUARTER + (ONE >>> s) + (u >> (s + 5));
      c.im = rand64() >>> $urandom_range(8, 63);
    end else if (kind < 88) begin
      s    = $urandom_range(4, 58);
      c.re = -TWO - (ONE >>> s) - (u >> (s + 5));
      c.im = rand64() >>> $urandom_range(8, 63);
    end else begin
      // small magnitudes down to a few lsbs, deep inside the set
      c.re = rand64() >>> $urandom_range(2, 63);
      c.im = rand64() >>> $urandom_range(2, 63);
    end
    return c;
  endfunction

  // one input transaction; the expectation is queued on acceptance so it
  // always sees the limit that the block itself uses
  task automatic send_point(input coord_pair_t c, input logic known,
                            input escape_result_t typed);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    c_real   <= c.re;
    c_imag   <= c.im;
    do @(posedge clk); while (in_stall);
    pending_escapes.push_back(known ? typed : predict_escape(c, limit_now));
    points_sent++;
    // idling profile: sender light / receiver heavy, then swapped, then none
    if (points_sent < POINTS_PLANNED / 3) begin
      send_idle_pct = 34;
      recv_idle_pct = 69;
    end else if (points_sent < 2 * POINTS_PLANNED / 3) begin
      send_idle_pct = 69;
      recv_idle_pct = 34;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  endtask

  // hold off the input until every expected result is back; the loop waits
  // on the clock before testing, so valid is never dropped and raised in the same step
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_escapes.size() != 0);
  endtask

  // limit register write, only called with the block idle
  task automatic write_limit(input logic [LIMIT_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    limit_now = v;
  endtask

  function automatic void note_mismatch(input string what);
    if (mismatches < REPORT_MAX) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
    mismatches++;
  endfunction

  // ---------------------------------------------------------------------------
  // output side: random stall and in-order compare
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    escape_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_escapes.size() == 0) begin
        note_mismatch($sformatf("result %0d with nothing pending: count %0d escaped %0b",
                                results_seen, count, escaped));
      end else begin
        want = pending_escapes.pop_front();
        if (count !== want.cnt) begin
          note_mismatch($sformatf("result %0d count expected %0d got %0d",
                                  results_seen, want.cnt, count));
        end
        if (escaped !== want.esc) begin
          note_mismatch($sformatf("result %0d escaped expected %0b got %0b",
                                  results_seen, want.esc, escaped));
        end
      end
      results_seen++;
    end
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // watchdog against a hung handshake or a lost result
  always @(posedge clk) begin
    cycles_run <= cycles_run + 1;
    if (cycles_run >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    coord_pair_t        c;
    escape_result_t     typed;
    logic [LIMIT_W-1:0] lim;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // directed table; the first rows run on the reset value of the limit
    for (int i = 0; i < PROBE_ROWS; i++) begin
      if (PROBES[i].limit != limit_now) begin
        drain_results();
        write_limit(PROBES[i].limit);
      end
      c.re      = PROBES[i].re;
      c.im      = PROBES[i].im;
      typed.cnt = PROBES[i].cnt;
      typed.esc = PROBES[i].esc;
      send_point(c, PROBES[i].known, typed);
    end

    // random sweeps, each under its own limit
    typed = '0;
    for (int p = 0; p < PHASE_COUNT; p++) begin
      if (PHASES[p].rand_limit) begin
        lim = LIMIT_W'($urandom_range(2, 120));
      end else begin
        lim = PHASES[p].limit;
      end
      drain_results();
      write_limit(lim);
      repeat (PHASES[p].points) begin
        send_point(pick_point(lim == MAX_LIMIT), 1'b0, typed);
        // now and then let the block run completely dry
        if ($urandom_range(99) < 3) begin
          drain_results();
        end
      end
    end

    // everything back, then a quiet window to catch stray results
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
